// ===== rtl/core/bse_pkg.sv =====
`default_nettype none

package bse_pkg;

    // Fixed field widths of the channels and the configuration register.
    localparam int LINE_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int OP_W      = 4;
    localparam int SEL_W     = 2;
    localparam int ELEM_W    = 10;
    localparam int RESULT_W  = 11;
    localparam int POP_W     = 7;
    localparam int CFG_W     = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam int DEF_NUM_SETS      = 4;
    localparam int DEF_WORDS_PER_SET = 16;

    localparam logic [LINE_BITS-1:0] M1 = 64'h5555555555555555;
    localparam logic [LINE_BITS-1:0] M2 = 64'h3333333333333333;
    localparam logic [LINE_BITS-1:0] M4 = 64'h0f0f0f0f0f0f0f0f;

    typedef enum logic [OP_W-1:0] {
        OP_SET        = 4'd0,
        OP_CLEAR      = 4'd1,
        OP_ZERO       = 4'd2,
        OP_COUNT      = 4'd3,
        OP_NEXT       = 4'd4,
        OP_COPY       = 4'd5,
        OP_UNION      = 4'd6,
        OP_INTERSECT  = 4'd7,
        OP_DIFFERENCE = 4'd8,
        OP_EQUAL      = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    // Control handed to the line unit with each line read back from storage.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             first;
        logic [BIT_W-1:0] bit_pos;
    } t_line_ctl;

    // Status the line unit returns to the sequencer.
    typedef struct packed {
        logic [POP_W-1:0] pop;
        logic             hit;
        logic [BIT_W-1:0] low;
        logic             differ;
    } t_line_res;

    function automatic logic [POP_W-1:0] pop64(input logic [LINE_BITS-1:0] w);
        logic [LINE_BITS-1:0] b;
        b = (w & M1) + ((w >> 1) & M1);
        b = (b & M2) + ((b >> 2) & M2);
        b = (b & M4) + ((b >> 4) & M4);
        b = b + (b >> 8);
        b = b + (b >> 16);
        b = b + (b >> 32);
        return b[POP_W-1:0];
    endfunction

    // Position of the lowest set bit by halving search; all ones for an empty line.
    function automatic logic [BIT_W-1:0] low_bit64(input logic [LINE_BITS-1:0] w);
        logic [LINE_BITS-1:0] v;
        logic [LINE_BITS-1:0] keep;
        logic [BIT_W-1:0]     n;
        v = w;
        n = '0;
        for (int k = BIT_W - 1; k >= 0; k--) begin
            keep = (64'd1 << (1 << k)) - 64'd1;
            if ((v & keep) == '0) begin
                n[k] = 1'b1;
                v    = v >> (1 << k);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bse_if.sv =====
`default_nettype none

interface bse_in_if import bse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SEL_W-1:0]  first_set;
    logic [SEL_W-1:0]  second_set;
    logic [ELEM_W-1:0] element;

    modport source (output valid, output operation, output first_set,
                    output second_set, output element, input ready);
    modport sink   (input valid, input operation, input first_set,
                    input second_set, input element, output ready);
endinterface

interface bse_out_if import bse_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] result_value;
    logic                found;
    logic                out_of_range;

    modport source (output valid, output result_value, output found,
                    output out_of_range, input ready);
    modport sink   (input valid, input result_value, input found,
                    input out_of_range, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bse_ram.sv =====
`default_nettype none

module bse_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [$clog2(DEPTH)-1:0]       i_waddr,
    input  wire logic [WIDTH-1:0]               i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]       i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]       i_raddr_b,
    output logic      [WIDTH-1:0]               o_rdata_a,
    output logic      [WIDTH-1:0]               o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/core/bse_line_unit.sv =====
`default_nettype none

module bse_line_unit import bse_pkg::*; (
    input  wire t_line_ctl              i_ctl,
    input  wire logic [LINE_BITS-1:0]   i_line_a,
    input  wire logic [LINE_BITS-1:0]   i_line_b,
    output logic      [LINE_BITS-1:0]   o_wdata,
    output logic                        o_we,
    output t_line_res                   o_res
);

    logic [LINE_BITS-1:0] bit_mask;
    logic [LINE_BITS-1:0] keep_mask;
    logic [LINE_BITS-1:0] masked;

    // For find-next only the first line visited is trimmed below the start bit.
    assign bit_mask  = 64'd1 << i_ctl.bit_pos;
    assign keep_mask = i_ctl.first ? ({LINE_BITS{1'b1}} << i_ctl.bit_pos)
                                   : {LINE_BITS{1'b1}};
    assign masked    = i_line_a & keep_mask;

    always_comb begin
        o_wdata = i_line_a;
        o_we    = 1'b1;
        case (i_ctl.op)
            OP_SET:        o_wdata = i_line_a | bit_mask;
            OP_CLEAR:      o_wdata = i_line_a & ~bit_mask;
            OP_ZERO:       o_wdata = '0;
            OP_COPY:       o_wdata = i_line_b;
            OP_UNION:      o_wdata = i_line_a | i_line_b;
            OP_INTERSECT:  o_wdata = i_line_a & i_line_b;
            OP_DIFFERENCE: o_wdata = i_line_a & ~i_line_b;
            default:       o_we    = 1'b0;
        endcase
    end

    assign o_res.pop    = pop64(i_line_a);
    assign o_res.hit    = (masked != '0);
    assign o_res.low    = low_bit64(masked);
    assign o_res.differ = (i_line_a != i_line_b);

endmodule

`default_nettype wire

// ===== rtl/core/bitset_store_engine_core.sv =====
`default_nettype none

// Channel     Direction  Handshake      Contents of one word
// i_in_ch     in         valid/ready    operation, first_set, second_set, element
// o_out_ch    out        valid/ready    result_value, found, out_of_range
// i_cfg_*     in         write enable   words_in_use (5 bits)
//
// After reset the engine sweeps all NUM_SETS * WORDS_PER_SET lines of the set
// storage, one line per cycle, and accepts no word until that is done.
// An operation walks the active lines, set and clear only the line holding the
// element and find-next up to its first hit. Each line is read from storage and
// a changed first set goes back through the single write port. The next word is
// taken once the walk is done; rejected set or clear, find-next beyond range and
// unknown codes skip the walk. A result waits in the output register; a stalled
// sink holds the engine only when a second result is ready to leave.

module bitset_store_engine_core import bse_pkg::*; #(
    parameter int NUM_SETS      = DEF_NUM_SETS,
    parameter int WORDS_PER_SET = DEF_WORDS_PER_SET
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    bse_in_if.sink                 i_in_ch,
    bse_out_if.source              o_out_ch
);

    localparam int DEPTH  = NUM_SETS * WORDS_PER_SET;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WIDX_W = (WORDS_PER_SET > 1) ? $clog2(WORDS_PER_SET) : 1;
    localparam int SET_W  = $clog2(NUM_SETS);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [8:0]        WPS9      = 9'(WORDS_PER_SET);
    localparam logic [6:0]        NSETS7    = 7'(NUM_SETS);

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [ADDR_W-1:0]    r_clr, n_clr;

    // Operation held for the whole walk.
    logic [OP_W-1:0]      r_op, n_op;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic [ADDR_W-1:0]    r_base_a, n_base_a;
    logic [ADDR_W-1:0]    r_base_b, n_base_b;
    logic [WIDX_W-1:0]    r_last, n_last;

    // Read issue side and the line whose data returns in the next cycle.
    logic [WIDX_W-1:0]    r_idx, n_idx;
    logic                 r_issue_done, n_issue_done;
    logic                 r_first_iss, n_first_iss;
    logic                 r_pend, n_pend;
    logic [WIDX_W-1:0]    r_pidx, n_pidx;
    logic                 r_pfirst, n_pfirst;

    // Accumulated result.
    logic [RESULT_W-1:0]  r_cnt, n_cnt;
    logic [RESULT_W-1:0]  r_value, n_value;
    logic                 r_found, n_found;
    logic                 r_oor, n_oor;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    logic [RESULT_W-1:0]  r_out_value, n_out_value;
    logic                 r_out_found, n_out_found;
    logic                 r_out_oor, n_out_oor;

    logic                 accept;
    logic                 out_load;
    logic                 issue;
    logic                 hit_next;
    logic                 last_line;

    // Decode of the arriving word.
    logic [8:0]           cfg9, nw9, ew9;
    logic                 elem_oor;
    logic                 op_unknown;
    logic                 op_point;
    logic                 go_direct;
    logic [6:0]           sa7, sb7, sa_m7, sb_m7;
    logic [SET_W-1:0]     sa, sb;

    logic [ADDR_W-1:0]    rd_addr_a, rd_addr_b;
    logic [ADDR_W-1:0]    wr_addr;
    logic [LINE_BITS-1:0] wr_data;
    logic                 wr_en;
    logic [LINE_BITS-1:0] rd_data_a, rd_data_b;

    t_line_ctl            line_ctl;
    t_line_res            line_res;
    logic [LINE_BITS-1:0] unit_wdata;
    logic                 unit_we;

    // Active line count, with zero taken as one and a value beyond the set
    // size taken as the set size.
    assign cfg9 = {4'b0, r_cfg};
    always_comb begin
        if (cfg9 == 9'd0) begin
            nw9 = 9'd1;
        end else if (cfg9 > WPS9) begin
            nw9 = WPS9;
        end else begin
            nw9 = cfg9;
        end
    end

    assign ew9        = {5'b0, i_in_ch.element[ELEM_W-1:BIT_W]};
    assign elem_oor   = (ew9 >= nw9);
    assign op_unknown = (i_in_ch.operation > OP_EQUAL);
    assign op_point   = (i_in_ch.operation == OP_SET) || (i_in_ch.operation == OP_CLEAR);
    assign go_direct  = op_unknown ||
                        ((op_point || (i_in_ch.operation == OP_NEXT)) && elem_oor);

    // Set selectors wrap modulo the set count; a two-bit selector is below
    // twice any legal set count, so one subtraction suffices.
    assign sa7   = {5'b0, i_in_ch.first_set};
    assign sb7   = {5'b0, i_in_ch.second_set};
    assign sa_m7 = (sa7 >= NSETS7) ? (sa7 - NSETS7) : sa7;
    assign sb_m7 = (sb7 >= NSETS7) ? (sb7 - NSETS7) : sb7;
    assign sa    = sa_m7[SET_W-1:0];
    assign sb    = sb_m7[SET_W-1:0];

    assign accept   = i_in_ch.valid && (r_state == ST_IDLE);
    assign out_load = (r_state == ST_FIN) && (!r_out_valid || o_out_ch.ready);
    assign issue    = (r_state == ST_RUN) && !r_issue_done;
    assign hit_next = r_pend && (r_op == OP_NEXT) && line_res.hit;
    assign last_line = r_pend && (r_pidx == r_last);

    assign i_in_ch.ready         = (r_state == ST_IDLE);
    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.result_value = r_out_value;
    assign o_out_ch.found        = r_out_found;
    assign o_out_ch.out_of_range = r_out_oor;

    // Storage: both sets of a line are read together, the first set is
    // written back in the cycle after the read; no write meets a used read on one line.
    assign rd_addr_a = r_base_a + ADDR_W'(r_idx);
    assign rd_addr_b = r_base_b + ADDR_W'(r_idx);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_data = '0;
        end else begin
            wr_en   = r_pend && unit_we && (r_state == ST_RUN);
            wr_addr = r_base_a + ADDR_W'(r_pidx);
            wr_data = unit_wdata;
        end
    end

    bse_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (rd_data_a),
        .o_rdata_b (rd_data_b)
    );

    assign line_ctl.op      = r_op;
    assign line_ctl.first   = r_pfirst;
    assign line_ctl.bit_pos = r_bit;

    bse_line_unit u_line (
        .i_ctl    (line_ctl),
        .i_line_a (rd_data_a),
        .i_line_b (rd_data_b),
        .o_wdata  (unit_wdata),
        .o_we     (unit_we),
        .o_res    (line_res)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = go_direct ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN: begin
                if (hit_next || last_line) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer and accumulator updates.
    always_comb begin
        n_clr        = r_clr;
        n_op         = r_op;
        n_bit        = r_bit;
        n_base_a     = r_base_a;
        n_base_b     = r_base_b;
        n_last       = r_last;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_first_iss  = r_first_iss;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_pfirst     = r_pfirst;
        n_cnt        = r_cnt;
        n_value      = r_value;
        n_found      = r_found;
        n_oor        = r_oor;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + ADDR_W'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    n_op         = i_in_ch.operation;
                    n_bit        = i_in_ch.element[BIT_W-1:0];
                    n_base_a     = ADDR_W'(sa) * ADDR_W'(WORDS_PER_SET);
                    n_base_b     = ADDR_W'(sb) * ADDR_W'(WORDS_PER_SET);
                    n_issue_done = 1'b0;
                    n_first_iss  = 1'b1;
                    n_pend       = 1'b0;
                    n_cnt        = '0;
                    n_value      = '0;
                    n_found      = (i_in_ch.operation == OP_EQUAL);
                    n_oor        = op_point && elem_oor;
                    // Set and clear touch the one line holding the element;
                    // find-next starts there and runs to the last active line or its first hit.
                    if (op_point || (i_in_ch.operation == OP_NEXT)) begin
                        n_idx = ew9[WIDX_W-1:0];
                    end else begin
                        n_idx = '0;
                    end
                    if (op_point) begin
                        n_last = ew9[WIDX_W-1:0];
                    end else begin
                        n_last = WIDX_W'(nw9 - 9'd1);
                    end
                end
            end
            ST_RUN: begin
                if (issue) begin
                    n_pend      = 1'b1;
                    n_pidx      = r_idx;
                    n_pfirst    = r_first_iss;
                    n_first_iss = 1'b0;
                    if (r_idx == r_last) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + WIDX_W'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    // The count is at most 31 lines of 64 bits, 1984, so the
                    // 11-bit accumulator never wraps.
                    n_cnt = r_cnt + RESULT_W'(line_res.pop);
                    if ((r_op == OP_EQUAL) && line_res.differ) begin
                        n_found = 1'b0;
                    end
                    if (hit_next) begin
                        n_found = 1'b1;
                        n_value = RESULT_W'({r_pidx, line_res.low});
                        n_pend  = 1'b0;
                    end
                end
            end
            ST_FIN: begin
                n_pend = 1'b0;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Output register: loads the finished result once the previous one has
    // gone, so a new word can start while a result is still waiting.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_found = r_out_found;
        n_out_oor   = r_out_oor;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_oor   = r_oor;
            case (r_op)
                OP_COUNT: begin
                    n_out_value = r_cnt;
                    n_out_found = 1'b0;
                end
                OP_NEXT: begin
                    n_out_value = r_value;
                    n_out_found = r_found;
                end
                OP_EQUAL: begin
                    n_out_value = '0;
                    n_out_found = r_found;
                end
                default: begin
                    n_out_value = '0;
                    n_out_found = 1'b0;
                end
            endcase
        end else if (r_out_valid && o_out_ch.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_cfg        <= CFG_RESET;
            r_issue_done <= 1'b0;
            r_first_iss  <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_issue_done <= n_issue_done;
            r_first_iss  <= n_first_iss;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_bit       <= n_bit;
        r_base_a    <= n_base_a;
        r_base_b    <= n_base_b;
        r_last      <= n_last;
        r_idx       <= n_idx;
        r_pidx      <= n_pidx;
        r_pfirst    <= n_pfirst;
        r_cnt       <= n_cnt;
        r_value     <= n_value;
        r_found     <= n_found;
        r_oor       <= n_oor;
        r_out_value <= n_out_value;
        r_out_found <= n_out_found;
        r_out_oor   <= n_out_oor;
    end

endmodule

`default_nettype wire
